### hw/rtl/elt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package elt_pkg;

  // Default build values
  localparam int TABLE_SLOTS_DEF = 64;
  localparam int PAGE_SHIFT_DEF  = 12;

  // Register reset values
  localparam logic [63:0] TAG_BASE_RST    = 64'h0000_0000_8000_0000;
  localparam logic [15:0] INVALID_ID_RST  = 16'h0000;
  localparam logic [15:0] MANAGER_ID_RST  = 16'hFFFF;
  localparam logic [15:0] NORMAL_ID_RST   = 16'hFFFE;
  localparam logic [15:0] NEXT_ID_RST     = 16'h0001;
  localparam logic [15:0] PAGES_MAX       = 16'hFFFF;

  typedef enum logic [1:0] {
    CFG_TAG_BASE   = 2'd0,
    CFG_INVALID_ID = 2'd1,
    CFG_MANAGER_ID = 2'd2,
    CFG_NORMAL_ID  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    REQ_CREATE   = 2'd0,
    REQ_DONATE   = 2'd1,
    REQ_FINALIZE = 2'd2
  } req_code_t;

  typedef enum logic [2:0] {
    RES_OK         = 3'd0,
    RES_FULL       = 3'd1,
    RES_NOTFOUND   = 3'd2,
    RES_MISALIGNED = 3'd3,
    RES_WRONGSTATE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    LC_EMPTY    = 2'd0,
    LC_CREATED  = 2'd1,
    LC_BUILDING = 2'd2,
    LC_LIVE     = 2'd3
  } lc_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_FINISH
  } fsm_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] enclave_id;
    logic [63:0] page_addr;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] new_id;
    logic [5:0]  slot_index;
    logic        tag_write;
    logic [51:0] tag_page;
    logic [15:0] tag_owner;
  } rsp_t;

  typedef struct packed {
    lc_t         state;
    logic [15:0] id;
    logic [15:0] pages;
    logic [63:0] entry;
  } rec_t;

  localparam rec_t REC_RESET = '{
    state: LC_EMPTY, id: INVALID_ID_RST, pages: 16'h0000, entry: 64'h0
  };

endpackage

`default_nettype wire

### hw/rtl/elt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module elt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/enclave_lifecycle_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Enclave lifecycle table: serves create, donate-page and finalize requests,
// one at a time, against TABLE_SLOTS enclave records held in a single
// synchronous RAM (state, ID, page count, entry address per slot). Every
// request that passes the early checks walks the RAM one slot per cycle from
// slot 0 until it finds the first free slot (create) or the first slot
// carrying the requested ID (donate, finalize), or until the last slot is
// read with no match. A donate that is misaligned, a donate or finalize
// naming a reserved ID and an unknown request type skip the walk. A
// finished request waits while the previous result beat is still held by a
// stall. One result beat leaves per request through an output register, so
// a new request is taken while a result still waits.
// A slot that was never written since reset reads as empty with the invalid
// ID held at reset (zero). Written slots always form a run from slot 0, since
// only a create can write an unwritten slot and it takes the lowest free one;
// a fill count marks the end of that run, so no clearing pass follows reset.
// Configuration writes are taken at any time; issue them only while the
// table is idle.

module enclave_lifecycle_table
  import elt_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int PAGE_SHIFT  = PAGE_SHIFT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire req_t        req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output rsp_t             rsp,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int IDX_W  = (SLOT_W > 6) ? SLOT_W : 6;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [SLOT_W-1:0] IDX_ONE  = SLOT_W'(1);
  localparam logic [SLOT_W:0]   FILL_ONE = (SLOT_W + 1)'(1);

  // Configuration registers
  logic [63:0] tag_base;
  logic [15:0] invalid_id;
  logic [15:0] manager_id;
  logic [15:0] normal_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_base   <= TAG_BASE_RST;
      invalid_id <= INVALID_ID_RST;
      manager_id <= MANAGER_ID_RST;
      normal_id  <= NORMAL_ID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TAG_BASE:   tag_base   <= cfg_data;
        CFG_INVALID_ID: invalid_id <= cfg_data[15:0];
        CFG_MANAGER_ID: manager_id <= cfg_data[15:0];
        CFG_NORMAL_ID:  normal_id  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Control and captured request
  fsm_t                    state, state_next;
  req_t                    req_q;
  logic [15:0]             next_id;
  logic [SLOT_W:0]         fill;

  logic [SLOT_W-1:0]       scan_addr;
  logic                    issue_done;
  logic                    chk_vld;
  logic [SLOT_W-1:0]       chk_idx;
  logic                    chk_valid_bit;

  logic                    found_q;
  logic                    fail_q;
  status_t                 fail_status;
  logic [SLOT_W-1:0]       hit_idx;
  rec_t                    hit_rec;

  // RAM side
  logic                    rd_en;
  logic [$bits(rec_t)-1:0] rd_data;
  rec_t                    chk_rec;
  logic                    ram_we;
  rec_t                    wr_rec;

  // Combinational decisions
  logic                    reserved;
  logic                    start_fail;
  status_t                 start_status;
  logic                    hit;
  logic                    last_miss;
  logic                    rsp_free;
  logic                    rsp_load;
  logic                    wr_do;
  rsp_t                    rsp_next;
  logic [IDX_W-1:0]        hit_idx_wide;
  logic                    tag_hit;
  logic [63:0]             tag_diff;
  logic [63:0]             tag_shifted;

  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  elt_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (hit_idx),
    .wr_data (wr_rec),
    .rd_en   (rd_en),
    .rd_addr (scan_addr),
    .rd_data (rd_data)
  );

  // A never-written slot reads as the reset record
  assign chk_rec = chk_valid_bit ? rec_t'(rd_data) : REC_RESET;

  assign reserved = (req_q.enclave_id == invalid_id) ||
                    (req_q.enclave_id == manager_id) ||
                    (req_q.enclave_id == normal_id);

  // Early rejection ahead of the walk
  always_comb begin
    start_fail   = 1'b0;
    start_status = RES_NOTFOUND;
    case (req_q.req_type)
      REQ_CREATE: begin
        start_fail = 1'b0;
      end
      REQ_DONATE: begin
        if (req_q.page_addr[PAGE_SHIFT-1:0] != '0) begin
          start_fail   = 1'b1;
          start_status = RES_MISALIGNED;
        end else if (reserved) begin
          start_fail = 1'b1;
        end
      end
      REQ_FINALIZE: begin
        start_fail = reserved;
      end
      default: begin
        start_fail = 1'b1;
      end
    endcase
  end

  // Compare the slot that arrived from the RAM this cycle
  always_comb begin
    if (req_q.req_type == REQ_CREATE) begin
      hit = chk_vld && (chk_rec.id == invalid_id);
    end else begin
      hit = chk_vld && (chk_rec.id == req_q.enclave_id);
    end
  end

  assign last_miss = chk_vld && !hit && (chk_idx == LAST_IDX);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        state_next = start_fail ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        if (hit || last_miss) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Result and write-back for the finishing request
  assign tag_hit      = (req_q.page_addr >= tag_base);
  assign tag_diff     = req_q.page_addr - tag_base;
  assign tag_shifted  = tag_diff >> PAGE_SHIFT;
  assign hit_idx_wide = IDX_W'(hit_idx);

  always_comb begin
    rsp_next            = '0;
    rsp_next.status     = RES_NOTFOUND;
    rsp_next.new_id     = invalid_id;
    wr_rec              = hit_rec;
    wr_do               = 1'b0;
    if (fail_q) begin
      rsp_next.status = fail_status;
    end else if (!found_q) begin
      rsp_next.status = (req_q.req_type == REQ_CREATE) ? RES_FULL : RES_NOTFOUND;
    end else begin
      rsp_next.slot_index = hit_idx_wide[5:0];
      case (req_q.req_type)
        REQ_CREATE: begin
          wr_rec          = '{state: LC_CREATED, id: next_id, pages: 16'h0000,
                              entry: 64'h0};
          wr_do           = 1'b1;
          rsp_next.new_id = next_id;
          rsp_next.status = RES_OK;
        end
        REQ_DONATE: begin
          if (hit_rec.state inside {LC_CREATED, LC_BUILDING}) begin
            if (hit_rec.state == LC_CREATED) begin
              wr_rec.entry = req_q.page_addr;
              wr_rec.state = LC_BUILDING;
            end
            if (hit_rec.pages != PAGES_MAX) begin
              wr_rec.pages = hit_rec.pages + 16'd1;
            end
            if (tag_hit) begin
              rsp_next.tag_write = 1'b1;
              rsp_next.tag_page  = tag_shifted[51:0];
              rsp_next.tag_owner = req_q.enclave_id;
            end
            wr_do           = 1'b1;
            rsp_next.status = RES_OK;
          end else begin
            rsp_next.status = RES_WRONGSTATE;
          end
        end
        REQ_FINALIZE: begin
          if (hit_rec.state == LC_BUILDING) begin
            wr_rec.state    = LC_LIVE;
            wr_do           = 1'b1;
            rsp_next.status = RES_OK;
          end else begin
            rsp_next.status = RES_WRONGSTATE;
          end
        end
        default: ;
      endcase
    end
  end

  // Outputs of the sequencer
  always_comb begin
    rd_en    = (state == S_SCAN) && !issue_done;
    rsp_load = (state == S_FINISH) && rsp_free;
    ram_we   = rsp_load && wr_do;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      next_id    <= NEXT_ID_RST;
      fill       <= '0;
      rsp_valid  <= 1'b0;
      chk_vld    <= 1'b0;
      issue_done <= 1'b0;
      found_q    <= 1'b0;
      fail_q     <= 1'b0;
    end else begin
      state <= state_next;

      case (state)
        S_IDLE: begin
          // Capture the request beat and arm the walk
          if (req_valid) begin
            req_q <= req;
          end
          scan_addr  <= '0;
          issue_done <= 1'b0;
          chk_vld    <= 1'b0;
          found_q    <= 1'b0;
          fail_q     <= 1'b0;
        end
        S_START: begin
          fail_q      <= start_fail;
          fail_status <= start_status;
        end
        S_SCAN: begin
          if (hit) begin
            found_q <= 1'b1;
            hit_idx <= chk_idx;
            hit_rec <= chk_rec;
            chk_vld <= 1'b0;
          end else begin
            // Advance the read pointer; the compare follows it through the RAM read register
            chk_vld       <= rd_en;
            chk_idx       <= scan_addr;
            chk_valid_bit <= ({1'b0, scan_addr} < fill);
            if (rd_en) begin
              if (scan_addr == LAST_IDX) begin
                issue_done <= 1'b1;
              end else begin
                scan_addr <= scan_addr + IDX_ONE;
              end
            end
          end
        end
        default: ;
      endcase

      if (ram_we) begin
        // A create into the first unwritten slot extends the written run
        if ({1'b0, hit_idx} == fill) begin
          fill <= fill + FILL_ONE;
        end
        if (req_q.req_type == REQ_CREATE) begin
          next_id <= next_id + 16'd1;
        end
      end

      // Hold the result beat until it is taken
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // Assertions
  a_load_shows_result: assert property (@(posedge clk) disable iff (rst)
    rsp_load |=> rsp_valid)
    else $error("result beat not presented after load");

  a_write_needs_slot: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (found_q && !fail_q && state == S_FINISH))
    else $error("table write without a located slot");

  a_miss_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && last_miss) |=> (state == S_FINISH && !found_q))
    else $error("walk past last slot did not finish as a miss");

  a_create_bumps_id: assert property (@(posedge clk) disable iff (rst)
    (ram_we && req_q.req_type == REQ_CREATE) |=> (next_id == $past(next_id) + 16'd1))
    else $error("create did not advance the ID counter");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_FINISH) |=> (state != S_START))
    else $error("new request started while one was in flight");

endmodule

`default_nettype wire

### verif/tb_enclave_lifecycle_table.sv
`timescale 1ns / 1ps

module tb_enclave_lifecycle_table;
  import elt_pkg::*;

  localparam int TABLE_SLOTS = TABLE_SLOTS_DEF;
  localparam int PAGE_SHIFT  = PAGE_SHIFT_DEF;
  // The request field is two bits wide, but only three codes are defined.
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 220;
  localparam int END_DRAIN   = 100;      // a full table walk plus the output register
  localparam int RUN_LIMIT   = 1000000;
  localparam int REPORT_CAP  = 40;

  logic        clk;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req       = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        cfg_we    = 1'b0;
  cfg_reg_t    cfg_index = CFG_TAG_BASE;
  logic [63:0] cfg_data  = '0;

  enclave_lifecycle_table dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the table. Only the lifecycle state and the ID of each slot are
  // visible at the result port, so the page count and the entry address are
  // not tracked.
  // ---------------------------------------------------------------------------
  logic [63:0] base_addr;     // lowest address that earns an owner tag
  logic [15:0] free_id;       // ID marking a free slot
  logic [15:0] mgr_id;
  logic [15:0] nw_id;
  logic [15:0] id_counter;    // next ID a create hands out
  lc_t         rec_lc [TABLE_SLOTS];
  logic [15:0] rec_id [TABLE_SLOTS];
  bit          last_create_ok;
  logic [15:0] last_create_id;

  req_t        req_pending  [$];   // beats waiting for the driver
  rsp_t        rsp_expected [$];   // predicted results, oldest first
  int          items_queued = 0;
  int          fail_count   = 0;

  bit          req_fire, rsp_fire; // handshake seen at the last rising edge
  int unsigned send_gap   = 0;
  bit          send_calm  = 1'b0;
  int unsigned drain_wait = 0;
  bit          drain_calm = 1'b0;
  int unsigned cycle_count = 0;

  // Reserved IDs never match; otherwise take the lowest slot carrying the ID.
  function automatic int find_enclave(logic [15:0] id);
    int hit = -1;
    if (id == free_id || id == mgr_id || id == nw_id) return -1;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (rec_id[i] == id) hit = i;
    end
    return hit;
  endfunction

  // Work out the result of one request and advance the shadow table.
  function automatic rsp_t service_request(req_t r);
    rsp_t o;
    int   s;
    o        = '0;
    o.status = RES_NOTFOUND;
    o.new_id = free_id;
    case (r.req_type)
      REQ_CREATE: begin
        s = -1;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
          if (rec_id[i] == free_id) s = i;
        end
        if (s < 0) begin
          o.status = RES_FULL;
        end else begin
          // the counter is handed out even when it collides with a reserved ID
          rec_lc[s]    = LC_CREATED;
          rec_id[s]    = id_counter;
          o.new_id     = id_counter;
          o.slot_index = 6'(s);
          o.status     = RES_OK;
          id_counter   = id_counter + 16'd1;
        end
        last_create_ok = (s >= 0);
        last_create_id = o.new_id;
      end
      REQ_DONATE: begin
        // alignment is judged before the lookup, so a bad page hides a bad ID
        s = find_enclave(r.enclave_id);
        if (r.page_addr[PAGE_SHIFT-1:0] != '0) begin
          o.status = RES_MISALIGNED;
        end else if (s >= 0) begin
          o.slot_index = 6'(s);
          if (rec_lc[s] == LC_CREATED || rec_lc[s] == LC_BUILDING) begin
            rec_lc[s] = LC_BUILDING;
            o.status  = RES_OK;
            // pages below the DRAM base are accepted but get no tag
            if (r.page_addr >= base_addr) begin
              o.tag_write = 1'b1;
              o.tag_page  = 52'((r.page_addr - base_addr) >> PAGE_SHIFT);
              o.tag_owner = r.enclave_id;
            end
          end else begin
            o.status = RES_WRONGSTATE;
          end
        end
      end
      REQ_FINALIZE: begin
        s = find_enclave(r.enclave_id);
        if (s >= 0) begin
          o.slot_index = 6'(s);
          if (rec_lc[s] == LC_BUILDING) begin
            rec_lc[s] = LC_LIVE;
            o.status  = RES_OK;
          end else begin
            o.status = RES_WRONGSTATE;
          end
        end
      end
      default: ;  // unknown code: no change, not-found answer
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    fail_count++;
    if (fail_count <= REPORT_CAP)
      $display("[%0t] result %s: got 0x%0h, want 0x%0h", $time, field, got, want);
  endtask

  task automatic check_rsp(rsp_t got, rsp_t want);
    if (got.status !== want.status)
      report_mismatch("status", 64'(got.status), 64'(want.status));
    if (got.new_id !== want.new_id)
      report_mismatch("new_id", 64'(got.new_id), 64'(want.new_id));
    if (got.slot_index !== want.slot_index)
      report_mismatch("slot_index", 64'(got.slot_index), 64'(want.slot_index));
    if (got.tag_write !== want.tag_write)
      report_mismatch("tag_write", 64'(got.tag_write), 64'(want.tag_write));
    if (got.tag_page !== want.tag_page)
      report_mismatch("tag_page", 64'(got.tag_page), 64'(want.tag_page));
    if (got.tag_owner !== want.tag_owner)
      report_mismatch("tag_owner", 64'(got.tag_owner), 64'(want.tag_owner));
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels and the register port at the rising edge.
  // Check the result beat before predicting, so a beat that appears on the
  // same edge as its own request cannot match its own prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_fire   <= 1'b0;
      rsp_fire   <= 1'b0;
      base_addr  = TAG_BASE_RST;
      free_id    = INVALID_ID_RST;
      mgr_id     = MANAGER_ID_RST;
      nw_id      = NORMAL_ID_RST;
      id_counter = NEXT_ID_RST;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        rec_lc[i] = LC_EMPTY;
        rec_id[i] = INVALID_ID_RST;
      end
    end else begin
      req_fire <= req_valid && !req_stall;
      rsp_fire <= rsp_valid && !rsp_stall;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TAG_BASE:   base_addr = cfg_data;
          CFG_INVALID_ID: free_id   = cfg_data[15:0];
          CFG_MANAGER_ID: mgr_id    = cfg_data[15:0];
          CFG_NORMAL_ID:  nw_id     = cfg_data[15:0];
          default: ;
        endcase
      end
      if (rsp_valid && !rsp_stall) begin
        if (rsp_expected.size() == 0)
          report_mismatch("beat with nothing pending", 64'(rsp.status), '0);
        else
          check_rsp(rsp, rsp_expected.pop_front());
      end
      if (req_valid && !req_stall)
        rsp_expected.push_back(service_request(req));
    end
  end

  function automatic int unsigned next_pause(bit calm);
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: change inputs at the falling edge. Hold a beat until it is taken,
  // then draw the gap before the next one; keep valid high across back-to-back
  // beats with a single assignment.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (req_valid) begin
        if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
        send_gap = next_pause(send_calm);
      end
      if (send_gap == 0 && req_pending.size() != 0) begin
        req       <= req_pending.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
        if (send_gap != 0) send_gap--;
      end
    end
  end

  // Result side: after every taken beat, draw how long to stall the next one.
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_fire) begin
        if ($urandom_range(0, 31) == 0) drain_calm = !drain_calm;
        drain_wait = next_pause(drain_calm);
      end
      rsp_stall <= (drain_wait != 0);
      if (drain_wait != 0) drain_wait--;
    end
  end

  // Cycle budget: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. They run just after the falling edge, when every update
  // of the rising edge has settled and the driver has made its move.
  // ---------------------------------------------------------------------------
  task automatic settle();
    @(negedge clk);
    #1;
  endtask

  task automatic queue_req(logic [1:0] kind, logic [15:0] id, logic [63:0] addr);
    req_t r;
    r.req_type   = kind;
    r.enclave_id = id;
    r.page_addr  = addr;
    req_pending.push_back(r);
    items_queued++;
  endtask

  // Drain the driver: every queued beat has been taken.
  task automatic wait_accepted();
    do settle(); while (req_pending.size() != 0 || req_valid);
  endtask

  // Drain both channels: every predicted result has arrived.
  task automatic wait_idle();
    do settle(); while (req_pending.size() != 0 || req_valid || rsp_expected.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [15:0] pick_known_id();
    return rec_id[$urandom_range(0, TABLE_SLOTS - 1)];
  endfunction

  // Page-aligned address: anywhere, at the extremes, or just either side of
  // the DRAM base.
  function automatic logic [63:0] aligned_page();
    logic [63:0] a;
    case ($urandom_range(0, 4))
      0:       a = {$urandom, $urandom};
      1:       a = '0;
      2:       a = '1;
      3:       a = base_addr + 64'({$urandom_range(0, 8), 12'h000});
      default: a = base_addr - 64'({$urandom_range(0, 8), 12'h000});
    endcase
    a[PAGE_SHIFT-1:0] = '0;
    return a;
  endfunction

  // A full lifecycle: create, learn the new ID, donate a few pages, finalize,
  // and now and then poke the finished enclave.
  task automatic build_enclave();
    logic [15:0] fresh;
    queue_req(REQ_CREATE, 16'($urandom), {$urandom, $urandom});
    wait_accepted();
    if (!last_create_ok) return;
    fresh = last_create_id;
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 9) == 0)
        queue_req(REQ_DONATE, fresh, {$urandom, $urandom});
      else
        queue_req(REQ_DONATE, fresh, aligned_page());
    end
    if ($urandom_range(0, 4) != 0)
      queue_req(REQ_FINALIZE, fresh, {$urandom, $urandom});
    if ($urandom_range(0, 3) == 0)
      queue_req($urandom_range(0, 1) ? REQ_DONATE : REQ_FINALIZE, fresh, aligned_page());
  endtask

  // Register settings per phase: zero and all-ones DRAM base, reserved IDs
  // that collide with the ID counter, a free marker that releases a live
  // slot, and a return to the reset values.
  task automatic configure_phase(int phase);
    case (phase)
      1: begin
        write_reg(CFG_TAG_BASE, 64'h0);
        write_reg(CFG_MANAGER_ID, 64'(id_counter));
      end
      2: begin
        write_reg(CFG_TAG_BASE, '1);
        write_reg(CFG_INVALID_ID, 64'(pick_known_id()));
        write_reg(CFG_NORMAL_ID, 64'h0);
      end
      3: begin
        write_reg(CFG_TAG_BASE, {$urandom, $urandom});
        write_reg(CFG_INVALID_ID, 64'(id_counter));
      end
      4: begin
        write_reg(CFG_TAG_BASE, TAG_BASE_RST);
        write_reg(CFG_INVALID_ID, 64'(INVALID_ID_RST));
        write_reg(CFG_MANAGER_ID, 64'(MANAGER_ID_RST));
        write_reg(CFG_NORMAL_ID, 64'(NORMAL_ID_RST));
      end
      5: begin
        write_reg(CFG_INVALID_ID, 64'hFFFF);
        write_reg(CFG_MANAGER_ID, 64'h0);
        write_reg(CFG_NORMAL_ID, 64'(pick_known_id()));
      end
      6: begin
        write_reg(CFG_TAG_BASE, {$urandom, 4'($urandom_range(0, 15)), 28'h0});
        write_reg(CFG_INVALID_ID, 64'(pick_known_id()));
        write_reg(CFG_MANAGER_ID, 64'($urandom_range(0, 16'hFFFF)));
        write_reg(CFG_NORMAL_ID, 64'($urandom_range(0, 16'hFFFF)));
      end
      7: begin
        write_reg(CFG_TAG_BASE, TAG_BASE_RST);
        write_reg(CFG_INVALID_ID, 64'(pick_known_id()));
        write_reg(CFG_MANAGER_ID, 64'(MANAGER_ID_RST));
        write_reg(CFG_NORMAL_ID, 64'(NORMAL_ID_RST));
      end
      default: ;  // first phase runs on the reset values
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          phase;
    int          phase_goal;
    int          pick;
    logic [1:0]  kind;
    logic [15:0] id;
    logic [63:0] addr;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    settle();

    // Directed: empty table, reserved IDs, alignment ahead of lookup, tags
    // below, at and at the top of DRAM, illegal state moves, unknown code.
    queue_req(REQ_FINALIZE, 16'h0001, 64'h0);
    queue_req(REQ_DONATE,   16'h0000, 64'h8000_0000);
    queue_req(REQ_CREATE,   16'h0000, 64'h0);
    queue_req(REQ_FINALIZE, 16'h0001, 64'h0);
    queue_req(REQ_DONATE,   16'h0001, 64'h8000_0001);
    queue_req(REQ_DONATE,   16'hFFFF, 64'h0000_0800);
    queue_req(REQ_DONATE,   16'h0001, 64'h7FFF_F000);
    queue_req(REQ_DONATE,   16'h0001, 64'h8000_0000);
    queue_req(REQ_DONATE,   16'h0001, 64'hFFFF_FFFF_FFFF_F000);
    queue_req(REQ_DONATE,   16'hFFFF, 64'h8000_1000);
    queue_req(REQ_DONATE,   16'hFFFE, 64'h8000_2000);
    queue_req(REQ_FINALIZE, 16'hFFFF, 64'h0);
    queue_req(REQ_UNKNOWN,  16'h0001, 64'h8000_3000);
    queue_req(REQ_FINALIZE, 16'h0001, 64'h0);
    queue_req(REQ_FINALIZE, 16'h0001, 64'h0);
    queue_req(REQ_DONATE,   16'h0001, 64'h8000_4000);
    queue_req(REQ_CREATE,   16'hFFFF, '1);
    queue_req(REQ_DONATE,   16'h0002, 64'h0);
    queue_req(REQ_DONATE,   16'hFFFF, '1);
    queue_req(REQ_CREATE,   16'h0000, 64'h0);
    queue_req(REQ_UNKNOWN,  16'hFFFF, '1);
    queue_req(REQ_DONATE,   16'h1234, 64'h9000_0000);
    queue_req(REQ_FINALIZE, 16'h0003, 64'h0);

    // Random phases: mostly lifecycles and donations or finalizes aimed at
    // enclaves that exist, the rest noise over every field.
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      configure_phase(phase);
      settle();
      phase_goal = items_queued + PHASE_ITEMS;
      while (items_queued < phase_goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          build_enclave();
        end else if (pick < 55) begin
          queue_req(REQ_DONATE, pick_known_id(), aligned_page());
        end else if (pick < 65) begin
          queue_req(REQ_FINALIZE, pick_known_id(), {$urandom, $urandom});
        end else begin
          kind = 2'($urandom_range(0, 3));
          case ($urandom_range(0, 4))
            0:       id = free_id;
            1:       id = mgr_id;
            2:       id = nw_id;
            3:       id = pick_known_id();
            default: id = 16'($urandom);
          endcase
          addr = $urandom_range(0, 1) ? {$urandom, $urandom} : aligned_page();
          queue_req(kind, id, addr);
        end
        // keep the queue short so targeted IDs track the table
        while (req_pending.size() > 4) settle();
      end
    end

    wait_idle();
    repeat (END_DRAIN) @(posedge clk);
    if (fail_count == 0 && rsp_expected.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/elt_pkg.sv
hw/rtl/elt_ram.sv
hw/rtl/enclave_lifecycle_table.sv
verif/tb_enclave_lifecycle_table.sv
